@@ rtl/wsa_pkg.sv @@
`timescale 1ns / 1ps

package wsa_pkg;

    // Sizing
    localparam int SAMPLERS    = 16;
    localparam int MAX_SAMPLES = 1024;

    localparam int ID_W   = 4;
    localparam int SEL_W  = (SAMPLERS > 1) ? $clog2(SAMPLERS) : 1;
    localparam int VAL_W  = 32;
    localparam int TIME_W = 32;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = VAL_W + $clog2(MAX_SAMPLES);
    localparam int NUM_W  = SUM_W + 2;
    localparam int DEN_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    // Configuration
    localparam int CLIM_W     = 11;
    localparam int TLIM_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CLIM_W-1:0]    COUNT_LIMIT_RST = 11'd1000;
    localparam logic [TLIM_W-1:0]    TIME_LIMIT_RST  = 16'd1000;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT  = 2'd1;

    // Operation codes; any other code reads
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [ID_W-1:0]   sampler_id;
        logic [VAL_W-1:0]  sample_value;
        logic [TIME_W-1:0] now_ms;
    } wsa_in_t;

    typedef struct packed {
        logic [VAL_W-1:0] average_out;
        logic             window_closed;
    } wsa_out_t;

    typedef struct packed {
        logic capture;
        logic load_entry;
        logic eval;
        logic div_start;
        logic finish;
    } wsa_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } wsa_status_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_EVAL   = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FINISH = 6'b100000
    } wsa_state_t;

endpackage

@@ rtl/windowed_sample_averager.sv @@
`timescale 1ns / 1ps

// Sequence: accept in idle, then read entry, evaluate, decide and finish; done is registered
//   after finish. A sample that closes its window adds a 44-bit serial divide before finish.
// Throughput: one command at a time; busy is high from acceptance until the result strobe.
// The result sits on result for the single cycle that done is high; the receiver cannot stall.
// Reset (rst_n low, async) clears all samplers and restores both limits to 1000.

module windowed_sample_averager (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  wsa_pkg::wsa_in_t               request,
    // result channel
    output logic                           done,
    output wsa_pkg::wsa_out_t              result,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wsa_pkg::*;

    wsa_cmd_t    cmd;
    wsa_status_t status;

    // Configuration registers take a transfer in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer: idle -> read entry -> evaluate -> decide -> (divide) -> finish.
    wsa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Sampler table, limit registers, add/compare logic and the rounding divider.
    wsa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

@@ rtl/wsa_ctrl.sv @@
`timescale 1ns / 1ps

module wsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  wsa_pkg::wsa_status_t status,
    output wsa_pkg::wsa_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import wsa_pkg::*;

    wsa_state_t state_reg;
    wsa_state_t state_next;
    logic       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FINISH);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.load_entry = 1'b1;
                state_next     = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

@@ rtl/wsa_div.sv @@
`timescale 1ns / 1ps

module wsa_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [wsa_pkg::NUM_W-1:0] num,
    input  logic [wsa_pkg::DEN_W-1:0] den,
    output logic [wsa_pkg::NUM_W-1:0] quot,
    output logic                      done
);
    import wsa_pkg::*;

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;
    logic [DEN_W-1:0]  rem_next;
    logic [NUM_W-1:0]  num_next;

    // restoring divide, one quotient bit per cycle; quotient shifts in behind the dividend
    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = !diff[DEN_W];
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_next = {num_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (load)
        begin
            step_reg <= STEP_W'(NUM_W);
            done_reg <= 1'b0;
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - STEP_W'(1);
            done_reg <= (step_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (step_reg != '0)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quot = num_reg;
    assign done = done_reg;

endmodule

@@ rtl/wsa_datapath.sv @@
`timescale 1ns / 1ps

module wsa_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wsa_pkg::wsa_in_t               request,
    input  wsa_pkg::wsa_cmd_t              cmd,
    output wsa_pkg::wsa_status_t           status,
    input  logic                           cfg_we,
    input  logic [wsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsa_pkg::CFG_DATA_W-1:0] cfg_data,
    output wsa_pkg::wsa_out_t              result
);
    import wsa_pkg::*;

    // configuration
    logic [CLIM_W-1:0] count_limit_reg;
    logic [TLIM_W-1:0] time_limit_reg;

    // per-sampler state
    logic [SUM_W-1:0]  sum_mem  [SAMPLERS];
    logic [CNT_W-1:0]  cnt_mem  [SAMPLERS];
    logic [TIME_W-1:0] last_mem [SAMPLERS];
    logic [VAL_W-1:0]  avg_mem  [SAMPLERS];

    wsa_in_t           req_reg;
    logic [SUM_W-1:0]  e_sum_reg;
    logic [CNT_W-1:0]  e_cnt_reg;
    logic [TIME_W-1:0] e_last_reg;
    logic [VAL_W-1:0]  e_avg_reg;

    logic [SUM_W-1:0]  w_sum_reg;
    logic [CNT_W-1:0]  w_cnt_reg;
    logic [TIME_W-1:0] w_last_reg;
    logic [VAL_W-1:0]  w_avg_reg;
    logic              close_reg;
    logic              wr_reg;

    wsa_out_t          result_reg;

    logic [SEL_W-1:0]  sel;
    logic              id_ok;
    logic [CNT_W-1:0]  lim;
    logic [SUM_W-1:0]  sum_add;
    logic [CNT_W-1:0]  cnt_add;
    logic [TIME_W-1:0] elapsed;
    logic              close_hit;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [NUM_W-1:0]  div_quot;
    logic              div_done;
    logic [VAL_W-1:0]  avg_final;

    assign sel   = req_reg.sampler_id[SEL_W-1:0];
    assign id_ok = (32'(req_reg.sampler_id) < 32'(SAMPLERS));

    always_comb
    begin
        if (32'(count_limit_reg) > 32'(MAX_SAMPLES))
        begin
            lim = CNT_W'(MAX_SAMPLES);
        end
        else
        begin
            lim = CNT_W'(count_limit_reg);
        end
        sum_add   = e_sum_reg + SUM_W'(req_reg.sample_value);
        cnt_add   = e_cnt_reg + CNT_W'(1);
        elapsed   = req_reg.now_ms - e_last_reg;
        close_hit = (cnt_add >= lim) || (elapsed >= TIME_W'(time_limit_reg));
    end

    // round half up: (2*sum + n) / (2*n)
    assign div_num   = NUM_W'({w_sum_reg, 1'b0}) + NUM_W'(w_cnt_reg);
    assign div_den   = {w_cnt_reg, 1'b0};
    assign avg_final = close_reg ? div_quot[VAL_W-1:0] : w_avg_reg;

    wsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    assign status.need_div = close_reg;
    assign status.div_done = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_limit_reg <= COUNT_LIMIT_RST;
            time_limit_reg  <= TIME_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COUNT_LIMIT: count_limit_reg <= cfg_data[CLIM_W-1:0];
                CFG_TIME_LIMIT:  time_limit_reg  <= cfg_data[TLIM_W-1:0];
                default:         ;
            endcase
        end
    end

    // sampler table, cleared by reset, written back at finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SAMPLERS; i++)
            begin
                sum_mem[i]  <= '0;
                cnt_mem[i]  <= '0;
                last_mem[i] <= '0;
                avg_mem[i]  <= '0;
            end
        end
        else if (cmd.finish && wr_reg)
        begin
            if (close_reg)
            begin
                sum_mem[sel]  <= '0;
                cnt_mem[sel]  <= '0;
                last_mem[sel] <= req_reg.now_ms;
            end
            else
            begin
                sum_mem[sel]  <= w_sum_reg;
                cnt_mem[sel]  <= w_cnt_reg;
                last_mem[sel] <= w_last_reg;
            end
            avg_mem[sel] <= avg_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_reg <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else if (cmd.eval)
        begin
            case (req_reg.func)
                FUNC_CLEAR:
                begin
                    close_reg <= 1'b0;
                    wr_reg    <= id_ok;
                end
                FUNC_SAMPLE:
                begin
                    close_reg <= id_ok && close_hit;
                    wr_reg    <= id_ok;
                end
                default:
                begin
                    close_reg <= 1'b0;
                    wr_reg    <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        if (cmd.load_entry)
        begin
            e_sum_reg  <= sum_mem[sel];
            e_cnt_reg  <= cnt_mem[sel];
            e_last_reg <= last_mem[sel];
            e_avg_reg  <= avg_mem[sel];
        end
        if (cmd.eval)
        begin
            case (req_reg.func)
                FUNC_CLEAR:
                begin
                    w_sum_reg  <= '0;
                    w_cnt_reg  <= '0;
                    w_last_reg <= req_reg.now_ms;
                    w_avg_reg  <= '0;
                end
                FUNC_SAMPLE:
                begin
                    w_sum_reg  <= sum_add;
                    w_cnt_reg  <= cnt_add;
                    w_last_reg <= e_last_reg;
                    w_avg_reg  <= e_avg_reg;
                end
                default:
                begin
                    w_sum_reg  <= e_sum_reg;
                    w_cnt_reg  <= e_cnt_reg;
                    w_last_reg <= e_last_reg;
                    w_avg_reg  <= e_avg_reg;
                end
            endcase
        end
        if (cmd.finish)
        begin
            result_reg.average_out   <= id_ok ? avg_final : '0;
            result_reg.window_closed <= close_reg;
        end
    end

    assign result = result_reg;

endmodule

@@ rtl/wsa_checker.sv @@
`timescale 1ns / 1ps

module wsa_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // a transfer in makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // no result can follow an acceptance directly
    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe right after acceptance");

    // one strobe per command
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // the strobe comes as the block returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a command");

endmodule

bind windowed_sample_averager wsa_checker u_wsa_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import wsa_pkg::*;

    // Second read code: the block treats the unused operation code as a read
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // Configuration indexes that map to no register; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    // Quiet cycles after the last result, longer than a closing divide
    localparam int TAIL_CYCLES = 60;

    // ------------------------------------------------------------------
    // Scoreboard: a private copy of the sampler table and the two limits,
    // updated on every accepted command and register write. Each accepted
    // command queues the one result it must produce.
    // ------------------------------------------------------------------
    class averager_scoreboard;
        logic [CLIM_W-1:0] count_limit;
        logic [TLIM_W-1:0] time_limit;
        logic [SUM_W-1:0]  win_sum   [SAMPLERS];
        logic [CNT_W-1:0]  win_count [SAMPLERS];
        logic [TIME_W-1:0] last_ms   [SAMPLERS];
        logic [VAL_W-1:0]  avg       [SAMPLERS];

        wsa_out_t averages_due[$];

        int accepted;
        int checked;
        int closes;
        int mismatches;

        function new();
            count_limit = COUNT_LIMIT_RST;
            time_limit  = TIME_LIMIT_RST;
            for (int i = 0; i < SAMPLERS; i++)
            begin
                win_sum[i]   = '0;
                win_count[i] = '0;
                last_ms[i]   = '0;
                avg[i]       = '0;
            end
            accepted   = 0;
            checked    = 0;
            closes     = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_COUNT_LIMIT)
                count_limit = data[CLIM_W-1:0];
            else if (idx == CFG_TIME_LIMIT)
                time_limit = data[TLIM_W-1:0];
        endfunction

        // Apply one command to the table and queue its result.
        function void note_request(wsa_in_t req);
            wsa_out_t          due;
            logic [SEL_W-1:0]  s;
            logic [CNT_W-1:0]  limit;
            logic [TIME_W-1:0] elapsed;
            logic [63:0]       num;
            logic [63:0]       den;
            due = '0;
            accepted++;
            if (req.sampler_id < SAMPLERS)
            begin
                s = req.sampler_id[SEL_W-1:0];
                case (req.func)
                    FUNC_CLEAR:
                    begin
                        win_sum[s]   = '0;
                        win_count[s] = '0;
                        last_ms[s]   = req.now_ms;
                        avg[s]       = '0;
                    end
                    FUNC_SAMPLE:
                    begin
                        // limits above the table depth saturate; zero closes every time
                        limit = (count_limit > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES) : count_limit;
                        win_sum[s]   = win_sum[s] + req.sample_value;
                        win_count[s] = win_count[s] + 1'b1;
                        elapsed      = req.now_ms - last_ms[s];
                        if (win_count[s] >= limit || elapsed >= time_limit)
                        begin
                            // round half up: floor((2*sum + n) / (2*n))
                            num    = 64'(win_sum[s]) * 2 + 64'(win_count[s]);
                            den    = 64'(win_count[s]) * 2;
                            avg[s] = VAL_W'(num / den);
                            win_sum[s]   = '0;
                            win_count[s] = '0;
                            last_ms[s]   = req.now_ms;
                            due.window_closed = 1'b1;
                            closes++;
                        end
                    end
                    default: ;
                endcase
                due.average_out = avg[s];
            end
            averages_due = {averages_due, due};
        endfunction

        function void check_result(wsa_out_t got);
            wsa_out_t want;
            if (averages_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result avg=%h closed=%b with no command outstanding",
                             got.average_out, got.window_closed);
                return;
            end
            want = averages_due.pop_front();
            checked++;
            if (got.average_out !== want.average_out)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d average_out expected %h got %h",
                             checked, want.average_out, got.average_out);
            end
            if (got.window_closed !== want.window_closed)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d window_closed expected %b got %b",
                             checked, want.window_closed, got.window_closed);
            end
        endfunction

        function int pending();
            return averages_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic     start   = 1'b0;
    logic     busy;
    wsa_in_t  request = '0;
    logic     done;
    wsa_out_t result;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always #1 clk = ~clk;

    windowed_sample_averager DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    averager_scoreboard sb = new();

    // Stimulus knobs, changed per phase
    int          sender_idle_pct = 0;
    int          focus_id        = 0;
    int          settings_run    = 0;
    logic [31:0] clock_ms;

    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Result monitor. The receiver cannot stall, so every strobe is a
    // transfer; values are sampled before this edge's updates land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles in which no transfer of any kind happens.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, sb.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one command. start is left high after the transfer so that a
    // back-to-back command never lowers and raises it in the same step.
    task automatic send_request(input wsa_in_t req);
        int gap;
        gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(req);
    endtask

    // Hold off new commands until every queued result has come back.
    // Only called right after a transfer, so at least one edge passes.
    task automatic wait_results_drained();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write both limits back to back; valid stays high across the transfers.
    // Optionally follows with a write to an unmapped index.
    task automatic write_limits(input logic [CFG_DATA_W-1:0] count_data,
                                input logic [CFG_DATA_W-1:0] time_data,
                                input bit with_spare);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] dat [3];
        int                    n;
        idx[0] = CFG_COUNT_LIMIT;
        dat[0] = count_data;
        idx[1] = CFG_TIME_LIMIT;
        dat[1] = time_data;
        idx[2] = $urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        dat[2] = CFG_DATA_W'($urandom);
        n = with_spare ? 3 : 2;
        for (int k = 0; k < n; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= dat[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.write_reg(idx[k], dat[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic wsa_in_t make_cmd(logic [1:0] func, int id, logic [31:0] value,
                                         logic [31:0] now);
        wsa_in_t c;
        c.func         = func;
        c.sampler_id   = ID_W'(id);
        c.sample_value = value;
        c.now_ms       = now;
        return c;
    endfunction

    // Mostly well-formed sample streams: a few samplers near focus_id, time
    // creeping forward slowly so windows close by count as well as by time.
    // The rest are clears, reads, and noise with arbitrary fields.
    function automatic wsa_in_t random_request(int span, int disturb_pct, int step_ms);
        wsa_in_t r;
        int      roll;
        roll     = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, step_ms);
        r.func       = FUNC_SAMPLE;
        r.sampler_id = ID_W'((focus_id + $urandom_range(0, span - 1)) % SAMPLERS);
        r.now_ms     = clock_ms;
        case ($urandom_range(0, 3))
            0:       r.sample_value = $urandom;
            1:       r.sample_value = 32'hFFFF_FFFF;
            2:       r.sample_value = $urandom_range(0, 15);
            default: r.sample_value = $urandom_range(0, 100000);
        endcase
        if (roll < disturb_pct)
            r.func = FUNC_CLEAR;
        else if (roll < 2 * disturb_pct)
        begin
            r.func         = 2'($urandom_range(0, 3));
            r.sampler_id   = ID_W'($urandom);
            r.sample_value = $urandom;
            r.now_ms       = $urandom;
        end
        else if (roll >= 92)
        begin
            r.func   = $urandom_range(0, 1) ? FUNC_READ : FUNC_SPARE;
            r.now_ms = $urandom;
        end
        return r;
    endfunction

    task automatic run_phase(input logic [CFG_DATA_W-1:0] count_data,
                             input logic [CFG_DATA_W-1:0] time_data,
                             input bit spare, input int idle_pct, input int step_ms,
                             input int span, input int disturb_pct, input int items);
        int pause_at;
        write_limits(count_data, time_data, spare);
        sender_idle_pct = idle_pct;
        focus_id        = $urandom_range(0, SAMPLERS - 1);
        pause_at        = $urandom_range(items / 4, 3 * items / 4);
        for (int n = 0; n < items; n++)
        begin
            send_request(random_request(span, disturb_pct, step_ms));
            if (n == pause_at)
                wait_results_drained();
        end
        wait_results_drained();
        settings_run++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        clock_ms = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset limits (1000 samples / 1000 ms)
        send_request(make_cmd(FUNC_CLEAR,  0, 32'd0,         32'd100));
        send_request(make_cmd(FUNC_SAMPLE, 0, 32'hFFFF_FFFF, 32'd100));
        send_request(make_cmd(FUNC_SAMPLE, 0, 32'd0,         32'd1099));
        // elapsed hits the time limit exactly
        send_request(make_cmd(FUNC_SAMPLE, 0, 32'd1,         32'd1100));
        send_request(make_cmd(FUNC_READ,   0, 32'd0,         32'd0));
        send_request(make_cmd(FUNC_SPARE,  0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // sampler never touched since reset
        send_request(make_cmd(FUNC_READ,   15, 32'd0,        32'd0));
        send_request(make_cmd(FUNC_SAMPLE, 15, 32'd0,        32'hFFFF_FFFF));
        // time running backwards wraps to a huge elapsed value
        send_request(make_cmd(FUNC_CLEAR,  1, 32'd0,         32'd5000));
        send_request(make_cmd(FUNC_SAMPLE, 1, 32'd12345,     32'd4000));
        // forward wrap of the millisecond counter
        send_request(make_cmd(FUNC_CLEAR,  2, 32'd0,         32'hFFFF_FF00));
        send_request(make_cmd(FUNC_SAMPLE, 2, 32'd7,         32'h0000_0010));
        send_request(make_cmd(FUNC_SAMPLE, 2, 32'd8,         32'h0000_0300));
        // clear after an average was stored
        send_request(make_cmd(FUNC_CLEAR,  0, 32'd0,         32'd0));
        send_request(make_cmd(FUNC_READ,   0, 32'd0,         32'd0));
        wait_results_drained();

        // Count closes after two samples: half-way rounds up, max average
        write_limits(16'd2, 16'hFFFF, 1'b0);
        send_request(make_cmd(FUNC_CLEAR,  3, 32'd0,         32'h8000_0000));
        send_request(make_cmd(FUNC_SAMPLE, 3, 32'd1,         32'h8000_0000));
        send_request(make_cmd(FUNC_SAMPLE, 3, 32'd2,         32'h8000_0001));
        send_request(make_cmd(FUNC_SAMPLE, 3, 32'hFFFF_FFFF, 32'h8000_0002));
        send_request(make_cmd(FUNC_SAMPLE, 3, 32'hFFFF_FFFE, 32'h8000_0003));
        wait_results_drained();

        // Both limits zero: every sample closes
        write_limits(16'd0, 16'd0, 1'b1);
        send_request(make_cmd(FUNC_SAMPLE, 5, 32'hAAAA_AAAA, 32'h1234_5678));
        send_request(make_cmd(FUNC_SAMPLE, 5, 32'h5555_5555, 32'h1234_5678));
        send_request(make_cmd(FUNC_READ,   5, 32'd0,         32'd0));
        wait_results_drained();
        settings_run = 3;

        // Random phases: count, time, spare write, idle %, ms step, span,
        // disturb %, items. Upper count bits are don't-care in the register.
        run_phase({5'($urandom), 11'd1}, 16'd1, 1'b0, 59, 2, 16, 8, 120);
        clock_ms = 32'hFFFF_FF00;
        run_phase(16'd3, 16'd50, 1'b1, 17, 8, 4, 6, 130);
        // one sampler, count limit saturates at the table depth
        run_phase(16'hFFFF, 16'hFFFF, 1'b0, 17, 2, 1, 0, 1120);
        run_phase(16'd7, 16'd200, 1'b0, 59, 20, 8, 5, 130);
        run_phase(16'd1024, 16'd300, 1'b1, 0, 5, 2, 3, 130);
        run_phase({5'($urandom), 11'd0}, 16'd0, 1'b0, 17, 3, 16, 10, 120);
        run_phase(16'(COUNT_LIMIT_RST), 16'(TIME_LIMIT_RST), 1'b0, 59, 30, 16, 6, 130);

        // Let any stray strobe show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            $display("ERROR: %0d expected results never arrived", sb.pending());
        $display("Covered %0d commands, %0d checked, %0d window closes, over %0d limit settings",
                 sb.accepted, sb.checked, sb.closes, settings_run);
        $display("Sender idle rates 0/17/59 percent, %0d mismatches", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/wsa_pkg.sv
rtl/wsa_ctrl.sv
rtl/wsa_div.sv
rtl/wsa_datapath.sv
rtl/windowed_sample_averager.sv
rtl/wsa_checker.sv
tb/tb_top.sv
